[rtl/core/rvx_pkg.sv]
// shared types and constants for the rv32i register alu executor
package rvx_pkg;

	localparam int XLEN    = 32;
	localparam int REG_W   = 5;
	localparam int SHAMT_W = 5;

	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_FENCE  = 7'h0F;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_SYSTEM = 7'h73;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL    = 7'h6F;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	typedef enum logic [1:0] {
		ST_EXEC  = 2'd0,
		ST_UNSUP = 2'd1,
		ST_OTHER = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_NONE  = 2'd0,
		K_ALU   = 2'd1,
		K_UPPER = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ALU_ADD  = 4'd0,
		ALU_SUB  = 4'd1,
		ALU_SLL  = 4'd2,
		ALU_SLT  = 4'd3,
		ALU_SLTU = 4'd4,
		ALU_XOR  = 4'd5,
		ALU_SRL  = 4'd6,
		ALU_SRA  = 4'd7,
		ALU_OR   = 4'd8,
		ALU_AND  = 4'd9
	} alu_op_t;

	// decoded request handed from the front end to the execute side
	typedef struct packed {
		status_t            status;
		kind_t              kind;
		alu_op_t            alu_op;
		logic [REG_W-1:0]   rd;
		logic [REG_W-1:0]   rs1;
		logic [REG_W-1:0]   rs2;
		logic [XLEN-1:0]    upper;
	} rvx_req_t;

endpackage

[rtl/core/rvx_front.sv]
// front end: decodes and classifies each instruction request
module rvx_front import rvx_pkg::*; (
	input  logic [XLEN-1:0] instruction,
	input  logic [XLEN-1:0] pc,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            q_full,
	output logic            q_push,
	output rvx_req_t        q_req
);

	logic [6:0]      op;
	logic [2:0]      f3;
	logic [6:0]      f7;
	logic [XLEN-1:0] u_imm;
	logic            f7_ok;

	assign op    = instruction[6:0];
	assign f3    = instruction[14:12];
	assign f7    = instruction[31:25];
	assign u_imm = {instruction[31:12], 12'b0};

	// alternate funct7 only for add/sub and the right shifts
	assign f7_ok = (f7 == F7_BASE) || ((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR)));

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_req.status = ST_UNSUP;
		q_req.kind   = K_NONE;
		q_req.alu_op = ALU_ADD;
		q_req.rd     = instruction[11:7];
		q_req.rs1    = instruction[19:15];
		q_req.rs2    = instruction[24:20];
		q_req.upper  = '0;
		case (op)
			OP_REG: begin
				if (f7_ok) begin
					q_req.status = ST_EXEC;
					q_req.kind   = K_ALU;
					case (f3)
						F3_ADD:  q_req.alu_op = (f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
						F3_SLL:  q_req.alu_op = ALU_SLL;
						F3_SLT:  q_req.alu_op = ALU_SLT;
						F3_SLTU: q_req.alu_op = ALU_SLTU;
						F3_XOR:  q_req.alu_op = ALU_XOR;
						F3_SR:   q_req.alu_op = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
						F3_OR:   q_req.alu_op = ALU_OR;
						F3_AND:  q_req.alu_op = ALU_AND;
						default: q_req.alu_op = ALU_ADD;
					endcase
				end
			end
			OP_LUI: begin
				q_req.status = ST_EXEC;
				q_req.kind   = K_UPPER;
				q_req.upper  = u_imm;
			end
			OP_AUIPC: begin
				q_req.status = ST_EXEC;
				q_req.kind   = K_UPPER;
				q_req.upper  = pc + u_imm;
			end
			OP_LOAD, OP_FENCE, OP_IMM, OP_JALR, OP_SYSTEM,
			OP_STORE, OP_BRANCH, OP_JAL: begin
				q_req.status = ST_OTHER;
			end
			default: begin
				q_req.status = ST_UNSUP;
			end
		endcase
	end

endmodule

[rtl/core/rvx_queue.sv]
// small fifo of decoded requests between front end and execute side
module rvx_queue import rvx_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rvx_req_t push_req,
	output logic     full,
	input  logic     pop,
	output logic     q_valid,
	output rvx_req_t q_req
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rvx_req_t         slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_req   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/rvx_back.sv]
// execute side: register file read, alu, write back and output register
module rvx_back import rvx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  rvx_req_t          q_req,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic              write_enable,
	output logic [REG_W-1:0]  dest_reg,
	output logic [XLEN-1:0]   write_value
);

	localparam int NREG = 2 ** REG_W;

	logic [XLEN-1:0]  rf_mem [NREG];
	logic [NREG-1:0]  rf_vld_q;

	logic             vld_s1;
	rvx_req_t         req_s1;
	logic [XLEN-1:0]  rfa_s1;
	logic [XLEN-1:0]  rfb_s1;
	logic             ok_a_s1;
	logic             ok_b_s1;
	logic             fwd_a_s1;
	logic             fwd_b_s1;
	logic [XLEN-1:0]  fwd_val_s1;

	logic             out_vld_q;
	status_t          status_q;
	logic             we_q;
	logic [REG_W-1:0] rd_q;
	logic [XLEN-1:0]  val_q;

	logic             exec_fire;
	logic             load_s1;
	logic             wr_en;
	logic [XLEN-1:0]  op_a;
	logic [XLEN-1:0]  op_b;
	logic [SHAMT_W-1:0] sh;
	logic [XLEN-1:0]  alu_val;
	logic [XLEN-1:0]  exe_val;

	assign exec_fire = vld_s1 && (!out_vld_q || !out_stall);
	assign load_s1   = !vld_s1 || exec_fire;
	assign q_pop     = q_valid && load_s1;
	assign wr_en     = exec_fire && (req_s1.status == ST_EXEC) && (req_s1.rd != '0);

	// bypass the write landing at the same edge, unwritten entries read zero
	assign op_a = fwd_a_s1 ? fwd_val_s1 : (ok_a_s1 ? rfa_s1 : '0);
	assign op_b = fwd_b_s1 ? fwd_val_s1 : (ok_b_s1 ? rfb_s1 : '0);
	assign sh   = op_b[SHAMT_W-1:0];

	always_comb begin
		case (req_s1.alu_op)
			ALU_ADD:  alu_val = op_a + op_b;
			ALU_SUB:  alu_val = op_a - op_b;
			ALU_SLL:  alu_val = op_a << sh;
			ALU_SLT:  alu_val = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(op_b)};
			ALU_SLTU: alu_val = {{(XLEN-1){1'b0}}, op_a < op_b};
			ALU_XOR:  alu_val = op_a ^ op_b;
			ALU_SRL:  alu_val = op_a >> sh;
			ALU_SRA:  alu_val = XLEN'($signed(op_a) >>> sh);
			ALU_OR:   alu_val = op_a | op_b;
			ALU_AND:  alu_val = op_a & op_b;
			default:  alu_val = '0;
		endcase
	end

	always_comb begin
		case (req_s1.kind)
			K_ALU:   exe_val = alu_val;
			K_UPPER: exe_val = req_s1.upper;
			default: exe_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[req_s1.rd] <= exe_val;
		end
		if (q_pop) begin
			rfa_s1     <= rf_mem[q_req.rs1];
			rfb_s1     <= rf_mem[q_req.rs2];
			req_s1     <= q_req;
			ok_a_s1    <= rf_vld_q[q_req.rs1];
			ok_b_s1    <= rf_vld_q[q_req.rs2];
			fwd_a_s1   <= wr_en && (req_s1.rd == q_req.rs1);
			fwd_b_s1   <= wr_en && (req_s1.rd == q_req.rs2);
			fwd_val_s1 <= exe_val;
		end
		if (exec_fire) begin
			status_q <= req_s1.status;
			we_q     <= wr_en;
			rd_q     <= req_s1.rd;
			val_q    <= exe_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				rf_vld_q[req_s1.rd] <= 1'b1;
			end
			if (load_s1) begin
				vld_s1 <= q_valid;
			end
			if (exec_fire) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign write_enable = we_q;
	assign dest_reg     = rd_q;
	assign write_value  = val_q;

`ifndef SYNTHESIS
	a_fire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_vld_q)
		else $error("executed request did not reach the output register");

	a_we_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && we_q |-> status_q == ST_EXEC && rd_q != '0)
		else $error("register write reported for a request that did not execute");

	a_x0_never_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!rf_vld_q[0])
		else $error("x0 marked as written");

	a_fwd_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && wr_en |=> vld_s1)
		else $error("request lost while a write back was bypassed");
`endif

endmodule

[rtl/core/rv32i_register_alu_executor_top.sv]
// top level of the rv32i register alu executor
// throughput: one instruction per cycle sustained while out_stall is low, set by the single execute stage
// path: an accepted request is written into the queue, read from the register file into the execute stage,
//   then taken through the alu into the output register
// the decode queue holds QUEUE_DEPTH requests, so input and output stall independently
// reset: arst_n clears the queue, pipeline valids and the per-register written flags;
//   unwritten registers read zero, so no clearing pass is needed
module rv32i_register_alu_executor_top import rvx_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// instruction requests
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [XLEN-1:0]   instruction,
	input  logic [XLEN-1:0]   pc,
	// results
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic              write_enable,
	output logic [REG_W-1:0]  dest_reg,
	output logic [XLEN-1:0]   write_value
);

	// front end to queue
	logic     q_full;
	logic     q_push;
	rvx_req_t push_req;

	// queue to execute side
	logic     q_valid;
	logic     q_pop;
	rvx_req_t q_req;

	// decode: classify opcode and funct fields, fold auipc add in here
	rvx_front u_front (
		.instruction (instruction),
		.pc          (pc),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_req       (push_req)
	);

	// decouples decode from execute so each side can stall alone
	rvx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (push_req),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_req    (q_req)
	);

	// register file read, alu, write back with same-edge bypass, output register
	rvx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.write_enable (write_enable),
		.dest_reg     (dest_reg),
		.write_value  (write_value)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the rv32i register alu executor
module testbench;
	import rvx_pkg::*;

	// run length guard, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 400000;
	// receiver hold-off used to fill the decode queue
	localparam int unsigned LONG_HOLD   = 200;
	// settle time after the last result
	localparam int unsigned DRAIN_WAIT  = 10;
	localparam int unsigned RANDOM_REQS = 690;

	// codes the package does not name
	localparam logic [6:0] OP_CUSTOM3 = 7'h7F;
	localparam logic [6:0] F7_BAD     = 7'h01;

	// one expected register write-back
	typedef struct {
		status_t          status;
		logic             we;
		logic [REG_W-1:0] rd;
		logic [XLEN-1:0]  value;
	} wb_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [XLEN-1:0]   instruction;
	logic [XLEN-1:0]   pc;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic              write_enable;
	logic [REG_W-1:0]  dest_reg;
	logic [XLEN-1:0]   write_value;

	// shadow register file, advanced once per accepted request
	logic [XLEN-1:0]   gpr_model [32];
	// write-backs still owed by the block, oldest first
	wb_t               pending_wb [$];
	wb_t               head_wb;

	int unsigned       err_count;
	int unsigned       cycle_count;

	// traffic shaping, set by the test tasks
	bit                tx_quiet;
	bit                rx_quiet;
	bit                hold_pending;
	bit                rx_stall_on;
	int unsigned       rx_left;

	rv32i_register_alu_executor_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.instruction  (instruction),
		.pc           (pc),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.write_enable (write_enable),
		.dest_reg     (dest_reg),
		.write_value  (write_value)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// x0 always reads zero
	function automatic logic [XLEN-1:0] gpr_read(logic [REG_W-1:0] idx);
		return (idx == '0) ? '0 : gpr_model[idx];
	endfunction

	// execute one instruction on the shadow state and return its write-back
	function automatic wb_t execute_instr(logic [XLEN-1:0] ins, logic [XLEN-1:0] addr);
		logic [6:0]         opcode;
		logic [2:0]         f3;
		logic [6:0]         f7;
		logic [XLEN-1:0]    a;
		logic [XLEN-1:0]    b;
		logic [SHAMT_W-1:0] sh;
		logic               alt;
		wb_t                r;
		opcode   = ins[6:0];
		f3       = ins[14:12];
		f7       = ins[31:25];
		r.status = ST_UNSUP;
		r.rd     = ins[11:7];
		r.value  = '0;
		case (opcode)
			OP_REG: begin
				a   = gpr_read(ins[19:15]);
				b   = gpr_read(ins[24:20]);
				sh  = b[SHAMT_W-1:0];
				alt = (f7 == F7_ALT);
				// only add/sub and the right shifts take the alternate funct7
				if (f7 == F7_BASE || (alt && (f3 == F3_ADD || f3 == F3_SR))) begin
					r.status = ST_EXEC;
					case (f3)
						F3_ADD:  r.value = alt ? a - b : a + b;
						F3_SLL:  r.value = a << sh;
						F3_SLT:  r.value = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
						F3_SLTU: r.value = {{(XLEN-1){1'b0}}, a < b};
						F3_XOR:  r.value = a ^ b;
						F3_SR: begin
							if (alt)
								r.value = $signed(a) >>> sh;
							else
								r.value = a >> sh;
						end
						F3_OR:   r.value = a | b;
						F3_AND:  r.value = a & b;
						default: r.value = '0;
					endcase
				end
			end
			OP_LUI: begin
				r.status = ST_EXEC;
				r.value  = {ins[31:12], 12'b0};
			end
			OP_AUIPC: begin
				r.status = ST_EXEC;
				r.value  = addr + {ins[31:12], 12'b0};
			end
			OP_LOAD, OP_FENCE, OP_IMM, OP_JALR, OP_SYSTEM,
			OP_STORE, OP_BRANCH, OP_JAL: begin
				r.status = ST_OTHER;
			end
			default: begin
				r.status = ST_UNSUP;
			end
		endcase
		// a write to x0 is computed and shown but never lands
		r.we = (r.status == ST_EXEC) && (r.rd != '0);
		if (r.we)
			gpr_model[r.rd] = r.value;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// instruction builders
	// ---------------------------------------------------------------

	function automatic logic [XLEN-1:0] r_type(logic [6:0] f7, logic [2:0] f3,
			logic [REG_W-1:0] rd, logic [REG_W-1:0] rs1, logic [REG_W-1:0] rs2);
		return {f7, rs2, rs1, f3, rd, OP_REG};
	endfunction

	function automatic logic [XLEN-1:0] u_type(logic [6:0] op, logic [19:0] imm,
			logic [REG_W-1:0] rd);
		return {imm, rd, op};
	endfunction

	// random upper bits under a chosen opcode
	function automatic logic [XLEN-1:0] with_opcode(logic [XLEN-1:0] word, logic [6:0] op);
		return {word[31:7], op};
	endfunction

	// mostly short idle stretches, a few long ones
	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(0, 2);
		if (pick < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// well-formed r-type and upper-immediate work with some noise mixed in
	function automatic logic [XLEN-1:0] gen_instr();
		int unsigned      pick;
		logic [2:0]       f3;
		logic [6:0]       f7;
		logic [REG_W-1:0] rd;
		logic [XLEN-1:0]  word;
		pick = $urandom_range(0, 99);
		f3   = 3'($urandom_range(0, 7));
		f7   = F7_BASE;
		if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1) == 1)
			f7 = F7_ALT;
		// x0 as destination now and then
		rd   = ($urandom_range(0, 19) == 0) ? '0 : REG_W'($urandom_range(1, 31));
		word = $urandom;
		if (pick < 62)
			return r_type(f7, f3, rd, word[19:15], word[24:20]);
		if (pick < 72)
			return u_type(OP_LUI, word[31:12], rd);
		if (pick < 80)
			return u_type(OP_AUIPC, word[31:12], rd);
		// broken funct7 on an otherwise valid r-type
		if (pick < 87)
			return r_type(word[31:25], f3, rd, word[19:15], word[24:20]);
		// formats the block recognizes but does not execute
		if (pick < 93) begin
			case ($urandom_range(0, 7))
				0:       return with_opcode(word, OP_LOAD);
				1:       return with_opcode(word, OP_FENCE);
				2:       return with_opcode(word, OP_IMM);
				3:       return with_opcode(word, OP_JALR);
				4:       return with_opcode(word, OP_SYSTEM);
				5:       return with_opcode(word, OP_STORE);
				6:       return with_opcode(word, OP_BRANCH);
				default: return with_opcode(word, OP_JAL);
			endcase
		end
		// anything at all
		return word;
	endfunction

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------

	// offer one request, hold it until accepted, predict, then maybe idle
	task automatic send_instr(input logic [XLEN-1:0] ins, input logic [XLEN-1:0] addr);
		int unsigned gap;
		in_valid    <= 1'b1;
		instruction <= ins;
		pc          <= addr;
		do
			@(posedge clk);
		while (in_stall);
		pending_wb.push_back(execute_instr(ins, addr));
		gap = tx_quiet ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering until every owed write-back has come out
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (pending_wb.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// extremes of the fields, every alu operation and each corner case
	task automatic test_directed();
		// upper immediates: all-ones, pc wrap, sign bit, shift amounts via pc
		send_instr(u_type(OP_LUI, 20'hFFFFF, 5'd1), $urandom);
		send_instr(u_type(OP_AUIPC, 20'h80000, 5'd2), 32'hFFFF_FFFF);
		send_instr(u_type(OP_LUI, 20'h80000, 5'd3), 32'h0);
		send_instr(u_type(OP_AUIPC, 20'h00000, 5'd5), 32'h0000_001F);
		// upper bits of the shift source must be masked off
		send_instr(u_type(OP_AUIPC, 20'h00000, 5'd6), 32'hFFFF_FFE4);
		// every alu operation
		send_instr(r_type(F7_BASE, F3_ADD, 5'd7, 5'd2, 5'd3), $urandom);
		send_instr(r_type(F7_ALT, F3_ADD, 5'd8, 5'd3, 5'd5), $urandom);
		send_instr(r_type(F7_BASE, F3_SLL, 5'd9, 5'd1, 5'd5), $urandom);
		send_instr(r_type(F7_BASE, F3_SLT, 5'd10, 5'd3, 5'd2), $urandom);
		send_instr(r_type(F7_BASE, F3_SLTU, 5'd11, 5'd3, 5'd2), $urandom);
		send_instr(r_type(F7_BASE, F3_XOR, 5'd12, 5'd1, 5'd2), $urandom);
		send_instr(r_type(F7_BASE, F3_SR, 5'd13, 5'd1, 5'd6), $urandom);
		// arithmetic shift of a negative and of a positive source
		send_instr(r_type(F7_ALT, F3_SR, 5'd14, 5'd1, 5'd6), $urandom);
		send_instr(r_type(F7_ALT, F3_SR, 5'd15, 5'd2, 5'd5), $urandom);
		send_instr(r_type(F7_BASE, F3_OR, 5'd16, 5'd3, 5'd5), $urandom);
		send_instr(r_type(F7_BASE, F3_AND, 5'd17, 5'd1, 5'd2), $urandom);
		// destination x0: value reported, nothing written
		send_instr(r_type(F7_BASE, F3_ADD, 5'd0, 5'd1, 5'd2), $urandom);
		// x0 as a source reads zero
		send_instr(r_type(F7_ALT, F3_ADD, 5'd18, 5'd0, 5'd1), $urandom);
		// funct7 outside the allowed set, and alternate funct7 on xor
		send_instr(r_type(F7_BAD, F3_ADD, 5'd19, 5'd1, 5'd2), $urandom);
		send_instr(r_type(F7_ALT, F3_XOR, 5'd20, 5'd1, 5'd2), $urandom);
		// i, s, b and j formats
		send_instr(with_opcode($urandom, OP_LOAD), $urandom);
		send_instr(with_opcode($urandom, OP_STORE), $urandom);
		send_instr(with_opcode($urandom, OP_BRANCH), $urandom);
		send_instr(with_opcode($urandom, OP_JAL), $urandom);
		// opcode with no meaning here
		send_instr(with_opcode($urandom, OP_CUSTOM3), $urandom);
	endtask

	// long random stream with idling on both sides
	task automatic test_random_mix(input int unsigned count);
		repeat (count)
			send_instr(gen_instr(), $urandom);
	endtask

	// receiver holds off while requests keep coming, so the queue fills
	task automatic test_backpressure();
		hold_pending = 1'b1;
		tx_quiet     = 1'b1;
		repeat (24)
			send_instr(gen_instr(), $urandom);
		tx_quiet     = 1'b0;
	endtask

	// full-rate stretch with no idling on either side
	task automatic test_back_to_back();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		repeat (40)
			send_instr(gen_instr(), $urandom);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	// alternating accept and stall bursts, or one long hold-off on request
	initial begin
		out_stall   = 1'b0;
		rx_stall_on = 1'b0;
		rx_left     = 0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rx_stall_on  = 1'b1;
				rx_left      = LONG_HOLD;
			end else if (rx_left != 0) begin
				rx_left--;
			end else if (rx_quiet) begin
				rx_stall_on = 1'b0;
			end else begin
				rx_stall_on = !rx_stall_on;
				rx_left     = rx_stall_on ? idle_len() : $urandom_range(0, 24);
			end
			out_stall <= rx_stall_on;
		end
	end

	task automatic check_field(input string name, input logic [XLEN-1:0] exp_v,
			input logic [XLEN-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	// compare every accepted result against the oldest write-back owed
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_wb.size() == 0) begin
				$display("%0t: unexpected result, status %0d we %0b rd %0d value %h",
					$time, status, write_enable, dest_reg, write_value);
				err_count++;
			end else begin
				head_wb = pending_wb.pop_front();
				check_field("status", XLEN'(head_wb.status), XLEN'(status));
				check_field("write_enable", XLEN'(head_wb.we), XLEN'(write_enable));
				check_field("dest_reg", XLEN'(head_wb.rd), XLEN'(dest_reg));
				check_field("write_value", head_wb.value, write_value);
			end
		end
	end

	// hard stop if the block hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout, %0d results still pending", $time, pending_wb.size());
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		instruction  = '0;
		pc           = '0;
		err_count    = 0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		hold_pending = 1'b0;
		for (int i = 0; i < 32; i++)
			gpr_model[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// sender waits for every result before the random part
		pause_until_drained();
		test_backpressure();
		test_random_mix(RANDOM_REQS / 2);
		test_back_to_back();
		test_random_mix(RANDOM_REQS / 2);

		pause_until_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
